>>> design/hex_img_pkg.sv
// types, codes and constants for the hex memory image parser
package hex_img_pkg;

    localparam int DEF_MAX_DIGITS = 8;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CONTIGUOUS_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS    = 1'd1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_COMMA   = 8'h2c;
    localparam logic [7:0] CHAR_X_LOW   = 8'h78;
    localparam logic [7:0] CHAR_X_UP    = 8'h58;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_A_LOW   = 8'h61;
    localparam logic [7:0] CHAR_F_LOW   = 8'h66;
    localparam logic [7:0] CHAR_A_UP    = 8'h41;
    localparam logic [7:0] CHAR_F_UP    = 8'h46;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_AT,
        PH_DIGITS,
        PH_PREFIX,
        PH_TRAIL1,
        PH_TRAIL2,
        PH_BAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_DONE,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_UNREADABLE,
        ERR_NO_START,
        ERR_BACKWARDS,
        ERR_AT_IN_CONTIGUOUS
    } err_code_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] data;
        err_code_t   error_code;
        logic        last;
    } out_item_t;

endpackage

>>> design/hex_memory_image_parser.sv
// hex memory image parser: line grammar check, address tracking and result queue
//
// Takes one text byte per item and may accept an item on every clock. Each item is
// decoded and its line state updated in the same cycle; the zero, one or two results
// it causes (a write, then a done or an error) go into a four-entry result queue.
// The input stalls while the queue holds more than two results, so the sustained rate
// is one item per cycle as long as the output side drains one result per cycle.
// Configuration may be written only while the block is idle.
module hex_memory_image_parser
    import hex_img_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item
);

    localparam int DC_W = $clog2(MAX_DIGITS + 1);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             contiguous_mode_reg;
    logic [31:0]      base_address_reg;

    phase_t           phase_reg, phase_next;
    logic [DC_W-1:0]  digit_count_reg, digit_count_next;
    logic [31:0]      acc_reg, acc_next;
    logic             has_at_reg, has_at_next;
    logic             lzs_reg, lzs_next;
    logic [31:0]      cur_addr_reg, cur_addr_next;
    logic             first_pending_reg, first_pending_next;
    logic             nonempty_reg, nonempty_next;
    logic             err_seen_reg, err_seen_next;

    out_item_t        fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    out_item_t        res0, res1;

    // line completion
    logic             line_ok;
    logic             fin_write;
    err_code_t        fin_err;
    logic [31:0]      fin_write_addr;
    logic [31:0]      fin_addr_after;
    logic             fin_fp_after;

    // character decode
    logic             is_space;
    logic             is_hex;
    logic [3:0]       hex_val;
    logic [7:0]       c;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = count_reg > CNT_W'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign out_item  = fifo_reg[rd_ptr_reg];
    assign c         = in_item.char_code;

    always_comb
    begin
        is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        is_hex   = 1'b1;
        hex_val  = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            hex_val = 4'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_A_LOW && c <= CHAR_F_LOW)
        begin
            hex_val = 4'(c - CHAR_A_LOW + 8'd10);
        end
        else if (c >= CHAR_A_UP && c <= CHAR_F_UP)
        begin
            hex_val = 4'(c - CHAR_A_UP + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        line_ok = (phase_reg == PH_DIGITS) || (phase_reg == PH_TRAIL1) ||
                  (phase_reg == PH_TRAIL2);
        fin_write      = 1'b0;
        fin_err        = ERR_NONE;
        fin_write_addr = cur_addr_reg;
        fin_addr_after = cur_addr_reg;
        fin_fp_after   = first_pending_reg;
        if (contiguous_mode_reg)
        begin
            fin_fp_after = 1'b0;
            if (first_pending_reg)
            begin
                fin_write_addr = base_address_reg;
                fin_addr_after = base_address_reg;
            end
            if (!line_ok)
            begin
                fin_err = ERR_UNREADABLE;
            end
            else if (has_at_reg)
            begin
                fin_err = ERR_AT_IN_CONTIGUOUS;
            end
            else
            begin
                fin_write      = 1'b1;
                fin_addr_after = fin_write_addr + 32'd1;
            end
        end
        else if (first_pending_reg)
        begin
            if (!line_ok || !has_at_reg)
            begin
                fin_err = ERR_NO_START;
            end
            else
            begin
                fin_addr_after = acc_reg;
                fin_fp_after   = 1'b0;
            end
        end
        else
        begin
            if (!line_ok)
            begin
                fin_err = ERR_UNREADABLE;
            end
            else if (has_at_reg)
            begin
                if (acc_reg < cur_addr_reg)
                begin
                    fin_err = ERR_BACKWARDS;
                end
                else
                begin
                    fin_addr_after = acc_reg;
                end
            end
            else
            begin
                fin_write      = 1'b1;
                fin_addr_after = cur_addr_reg + 32'd1;
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        digit_count_next   = digit_count_reg;
        acc_next           = acc_reg;
        has_at_next        = has_at_reg;
        lzs_next           = lzs_reg;
        cur_addr_next      = cur_addr_reg;
        first_pending_next = first_pending_reg;
        nonempty_next      = nonempty_reg;
        err_seen_next      = err_seen_reg;
        push_n             = 2'd0;

        res0 = '{kind: KIND_WRITE, address: fin_write_addr, data: acc_reg,
                 error_code: ERR_NONE, last: 1'b0};
        res1 = res0;

        if (in_item.end_of_input)
        begin
            if (!err_seen_reg)
            begin
                if (nonempty_reg && fin_write)
                begin
                    push_n = 2'd1;
                end
                if (nonempty_reg && fin_err != ERR_NONE)
                begin
                    res1 = '{kind: KIND_ERROR, address: '0, data: '0,
                             error_code: fin_err, last: 1'b1};
                end
                else
                begin
                    res1 = '{kind: KIND_DONE, address: '0, data: '0,
                             error_code: ERR_NONE, last: 1'b1};
                    if (nonempty_reg ? fin_fp_after : first_pending_reg)
                    begin
                        res1.address = contiguous_mode_reg ? base_address_reg : 32'd0;
                    end
                    else
                    begin
                        res1.address = nonempty_reg ? fin_addr_after : cur_addr_reg;
                    end
                end
                if (push_n == 2'd1)
                begin
                    push_n = 2'd2;
                end
                else
                begin
                    res0   = res1;
                    push_n = 2'd1;
                end
            end
            phase_next         = PH_LEAD;
            digit_count_next   = '0;
            acc_next           = '0;
            has_at_next        = 1'b0;
            lzs_next           = 1'b0;
            nonempty_next      = 1'b0;
            cur_addr_next      = '0;
            first_pending_next = 1'b1;
            err_seen_next      = 1'b0;
        end
        else if (err_seen_reg)
        begin
            push_n = 2'd0;
        end
        else if (c == CHAR_NEWLINE)
        begin
            if (fin_write)
            begin
                push_n = 2'd1;
            end
            else if (fin_err != ERR_NONE)
            begin
                res0 = '{kind: KIND_ERROR, address: '0, data: '0,
                         error_code: fin_err, last: 1'b1};
                push_n        = 2'd1;
                err_seen_next = 1'b1;
            end
            cur_addr_next      = fin_addr_after;
            first_pending_next = fin_fp_after;
            phase_next         = PH_LEAD;
            digit_count_next   = '0;
            acc_next           = '0;
            has_at_next        = 1'b0;
            lzs_next           = 1'b0;
            nonempty_next      = 1'b0;
        end
        else
        begin
            nonempty_next = 1'b1;
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (c == CHAR_AT)
                    begin
                        has_at_next = 1'b1;
                        phase_next  = PH_AT;
                    end
                    else if (is_hex)
                    begin
                        acc_next         = {acc_reg[27:0], hex_val};
                        digit_count_next = DC_W'(1);
                        lzs_next         = hex_val == 4'd0;
                        phase_next       = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_AT, PH_PREFIX:
                begin
                    if (is_hex)
                    begin
                        acc_next         = {acc_reg[27:0], hex_val};
                        digit_count_next = DC_W'(1);
                        lzs_next         = (phase_reg == PH_AT) && (hex_val == 4'd0);
                        phase_next       = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_DIGITS:
                begin
                    if ((c == CHAR_X_LOW || c == CHAR_X_UP) && lzs_reg)
                    begin
                        acc_next         = '0;
                        digit_count_next = '0;
                        lzs_next         = 1'b0;
                        phase_next       = PH_PREFIX;
                    end
                    else if (is_hex)
                    begin
                        if (digit_count_reg >= DC_W'(MAX_DIGITS))
                        begin
                            phase_next = PH_BAD;
                        end
                        else
                        begin
                            acc_next         = {acc_reg[27:0], hex_val};
                            digit_count_next = digit_count_reg + DC_W'(1);
                            lzs_next         = 1'b0;
                            phase_next       = PH_DIGITS;
                        end
                    end
                    else if (is_space)
                    begin
                        phase_next = PH_TRAIL1;
                    end
                    else if (c == CHAR_COMMA)
                    begin
                        phase_next = PH_TRAIL2;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_TRAIL1:
                begin
                    if (c == CHAR_COMMA)
                    begin
                        phase_next = PH_TRAIL2;
                    end
                    else if (!is_space)
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_TRAIL2:
                begin
                    if (!is_space)
                    begin
                        phase_next = PH_BAD;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contiguous_mode_reg <= 1'b0;
            base_address_reg    <= '0;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                REG_CONTIGUOUS_MODE: contiguous_mode_reg <= write_data[0];
                REG_BASE_ADDRESS:    base_address_reg    <= write_data;
                default:             contiguous_mode_reg <= contiguous_mode_reg;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEAD;
            digit_count_reg   <= '0;
            acc_reg           <= '0;
            has_at_reg        <= 1'b0;
            lzs_reg           <= 1'b0;
            cur_addr_reg      <= '0;
            first_pending_reg <= 1'b1;
            nonempty_reg      <= 1'b0;
            err_seen_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            digit_count_reg   <= digit_count_next;
            acc_reg           <= acc_next;
            has_at_reg        <= has_at_next;
            lzs_reg           <= lzs_next;
            cur_addr_reg      <= cur_addr_next;
            first_pending_reg <= first_pending_next;
            nonempty_reg      <= nonempty_next;
            err_seen_reg      <= err_seen_next;
        end
    end

    // result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? CNT_W'(push_n) : CNT_W'(0))
                         - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (accept && push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (accept && push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res1;
        end
    end

endmodule

>>> tb/tb_hex_memory_image_parser.sv
// testbench for the hex memory image parser: directed and random text images against a line predictor
module tb_hex_memory_image_parser;
    import hex_img_pkg::*;

    localparam int MAX_DIG = DEF_MAX_DIGITS;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        out_item_t  want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   write_enable;
    logic [CFG_INDEX_W-1:0] write_index;
    logic [CFG_DATA_W-1:0]  write_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_item;

    hex_memory_image_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

    // predictor state
    logic        mode_contig;
    logic [31:0] base_addr;
    phase_t      ln_phase;
    int unsigned ln_digits;
    logic [31:0] ln_value;
    logic        ln_at;
    logic        ln_zero;
    logic        ln_nonempty;
    logic [31:0] cur_addr;
    logic        first_pending;
    logic        err_latched;

    out_item_t     new_results[$];
    out_item_t     pending_results[$];
    directed_row_t directed_rows[$];

    logic sender_gaps = 1'b1;
    logic recv_gaps = 1'b1;
    logic hold_request = 1'b0;

    int items_sent = 0;
    int images_sent = 0;
    int reg_writes = 0;
    int n_write = 0;
    int n_done = 0;
    int n_error = 0;
    int mismatches = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void add_result(out_item_t r);
        new_results.insert(new_results.size(), r);
    endfunction

    function automatic void add_expected(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic out_item_t make_result(kind_t k, logic [31:0] a, logic [31:0] d,
                                              err_code_t e, logic l);
        out_item_t r;
        r.kind       = k;
        r.address    = a;
        r.data       = d;
        r.error_code = e;
        r.last       = l;
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return int'(c - CHAR_ZERO);
        if (c >= CHAR_A_LOW && c <= CHAR_F_LOW)
            return int'(c - CHAR_A_LOW) + 10;
        if (c >= CHAR_A_UP && c <= CHAR_F_UP)
            return int'(c - CHAR_A_UP) + 10;
        return -1;
    endfunction

    function automatic void clear_line();
        ln_phase    = PH_LEAD;
        ln_digits   = 0;
        ln_value    = '0;
        ln_at       = 1'b0;
        ln_zero     = 1'b0;
        ln_nonempty = 1'b0;
    endfunction

    function automatic void rearm_image();
        clear_line();
        cur_addr      = '0;
        first_pending = 1'b1;
        err_latched   = 1'b0;
    endfunction

    function automatic void take_digit(int v, logic first);
        if (!first && ln_digits >= MAX_DIG)
        begin
            ln_phase = PH_BAD;
            return;
        end
        ln_value  = {ln_value[27:0], 4'(v)};
        ln_digits = first ? 1 : ln_digits + 1;
        ln_zero   = first && v == 0 && ln_phase != PH_PREFIX;
        ln_phase  = PH_DIGITS;
    endfunction

    function automatic void feed_char(logic [7:0] c);
        int   v;
        logic taken;
        v = hex_digit(c);
        taken = 1'b0;
        ln_nonempty = 1'b1;
        case (ln_phase)
            PH_LEAD:
            begin
                if (is_blank(c))
                    taken = 1'b1;
                else if (c == CHAR_AT)
                begin
                    ln_at = 1'b1;
                    ln_phase = PH_AT;
                    taken = 1'b1;
                end
                else if (v >= 0)
                begin
                    take_digit(v, 1'b1);
                    taken = 1'b1;
                end
            end
            PH_AT, PH_PREFIX:
            begin
                if (v >= 0)
                begin
                    take_digit(v, 1'b1);
                    taken = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if ((c == CHAR_X_LOW || c == CHAR_X_UP) && ln_zero)
                begin
                    ln_value = '0;
                    ln_digits = 0;
                    ln_zero = 1'b0;
                    ln_phase = PH_PREFIX;
                    taken = 1'b1;
                end
                else if (v >= 0)
                begin
                    take_digit(v, 1'b0);
                    taken = 1'b1;
                end
                else if (is_blank(c))
                begin
                    ln_phase = PH_TRAIL1;
                    taken = 1'b1;
                end
                else if (c == CHAR_COMMA)
                begin
                    ln_phase = PH_TRAIL2;
                    taken = 1'b1;
                end
            end
            PH_TRAIL1:
            begin
                if (is_blank(c))
                    taken = 1'b1;
                else if (c == CHAR_COMMA)
                begin
                    ln_phase = PH_TRAIL2;
                    taken = 1'b1;
                end
            end
            PH_TRAIL2:
                taken = is_blank(c);
            default:
                taken = 1'b1;
        endcase
        if (!taken)
            ln_phase = PH_BAD;
    endfunction

    function automatic void finish_line();
        logic        well_formed;
        logic [31:0] val;
        err_code_t   err;
        well_formed = ln_phase == PH_DIGITS || ln_phase == PH_TRAIL1 || ln_phase == PH_TRAIL2;
        val = ln_value;
        err = ERR_NONE;
        if (mode_contig)
        begin
            if (first_pending)
            begin
                cur_addr = base_addr;
                first_pending = 1'b0;
            end
            if (!well_formed)
                err = ERR_UNREADABLE;
            else if (ln_at)
                err = ERR_AT_IN_CONTIGUOUS;
            else
            begin
                add_result(make_result(KIND_WRITE, cur_addr, val, ERR_NONE, 1'b0));
                cur_addr = cur_addr + 32'd1;
            end
        end
        else if (first_pending)
        begin
            if (!well_formed || !ln_at)
                err = ERR_NO_START;
            else
            begin
                cur_addr = val;
                first_pending = 1'b0;
            end
        end
        else
        begin
            if (!well_formed)
                err = ERR_UNREADABLE;
            else if (ln_at)
            begin
                if (val < cur_addr)
                    err = ERR_BACKWARDS;
                else
                    cur_addr = val;
            end
            else
            begin
                add_result(make_result(KIND_WRITE, cur_addr, val, ERR_NONE, 1'b0));
                cur_addr = cur_addr + 32'd1;
            end
        end
        if (err != ERR_NONE)
        begin
            err_latched = 1'b1;
            add_result(make_result(KIND_ERROR, '0, '0, err, 1'b1));
        end
        clear_line();
    endfunction

    function automatic void parse_item(in_item_t it);
        new_results.delete();
        if (it.end_of_input)
        begin
            if (!err_latched && ln_nonempty)
                finish_line();
            if (!err_latched)
            begin
                if (first_pending)
                    cur_addr = mode_contig ? base_addr : 32'd0;
                add_result(make_result(KIND_DONE, cur_addr, '0, ERR_NONE, 1'b1));
            end
            rearm_image();
        end
        else if (!err_latched)
        begin
            if (it.char_code == CHAR_NEWLINE)
                finish_line();
            else
                feed_char(it.char_code);
        end
    endfunction

    function automatic void add_row(logic [7:0] ch, logic eoi);
        directed_row_t r;
        r.ch    = ch;
        r.eoi   = eoi;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_typed(logic [7:0] ch, logic eoi, out_item_t want);
        directed_row_t r;
        r.ch    = ch;
        r.eoi   = eoi;
        r.typed = 1'b1;
        r.want  = want;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
        if (nib < 4'd10)
            return CHAR_ZERO + {4'd0, nib};
        return (upper ? CHAR_A_UP : CHAR_A_LOW) + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CHAR_TAB;
            1: return CHAR_TAB + 8'd2;
            2: return CHAR_TAB + 8'd3;
            3: return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_NEWLINE)
            c = CHAR_SPACE;
        return c;
    endfunction

    function automatic logic [31:0] start_address();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            1: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] next_address();
        case ($urandom_range(0, 5))
            0: return cur_addr - 32'($urandom_range(1, 4));
            1: return cur_addr;
            default: return cur_addr + 32'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [31:0] data_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    task automatic drive_item(in_item_t it, logic typed, out_item_t want);
        logic counted;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        counted = it.end_of_input || !err_latched;
        parse_item(it);
        if (typed)
            add_expected(want);
        else
            foreach (new_results[i])
                add_expected(new_results[i]);
        if (counted)
            items_sent++;
        if (it.end_of_input)
            images_sent++;
    endtask

    task automatic send_byte(logic [7:0] c);
        in_item_t it;
        it.char_code = c;
        it.end_of_input = 1'b0;
        drive_item(it, 1'b0, '0);
    endtask

    task automatic send_eoi();
        in_item_t it;
        it.char_code = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        drive_item(it, 1'b0, '0);
    endtask

    task automatic send_hex(logic [31:0] value);
        int lo;
        int nd;
        lo = 1;
        while (lo < 8 && (value >> (4 * lo)) != 0)
            lo++;
        nd = ($urandom_range(0, 3) == 0) ? int'($urandom_range(lo, 8)) : lo;
        for (int i = nd - 1; i >= 0; i--)
            send_byte(hex_char(value[4*i +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic send_line(logic with_at, logic [31:0] value, logic newline);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_byte(pick_blank());
        if (with_at)
            send_byte(CHAR_AT);
        if ($urandom_range(0, 3) == 0)
        begin
            send_byte(CHAR_ZERO);
            send_byte($urandom_range(0, 1) ? CHAR_X_UP : CHAR_X_LOW);
        end
        send_hex(value);
        case ($urandom_range(0, 5))
            0: send_byte(pick_blank());
            1: send_byte(CHAR_COMMA);
            2:
            begin
                send_byte(pick_blank());
                send_byte(CHAR_COMMA);
                send_byte(pick_blank());
            end
            default: ;
        endcase
        if (newline)
            send_byte(CHAR_NEWLINE);
    endtask

    task automatic send_broken();
        case ($urandom_range(0, 8))
            0: ;
            1: repeat ($urandom_range(9, 11))
                send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            2: repeat ($urandom_range(1, 5)) send_byte(random_byte());
            3:
            begin
                send_byte(CHAR_ZERO);
                send_byte(CHAR_X_LOW);
            end
            4:
            begin
                send_byte(CHAR_AT);
                send_byte(pick_blank());
                send_byte(CHAR_ZERO + 8'd5);
            end
            5:
            begin
                send_byte(CHAR_ZERO);
                send_byte(CHAR_X_UP);
                send_byte(CHAR_ZERO);
                send_byte(CHAR_X_LOW);
            end
            6:
            begin
                send_byte(CHAR_ZERO);
                send_byte(CHAR_ZERO);
                send_byte(CHAR_X_UP);
            end
            7: send_byte(pick_blank());
            default:
            begin
                send_byte(CHAR_ZERO + 8'd1);
                send_byte(CHAR_COMMA);
                send_byte(CHAR_COMMA);
            end
        endcase
        send_byte(CHAR_NEWLINE);
    endtask

    task automatic send_image();
        int   nlines;
        int   pick;
        logic newline;
        if (items_sent >= 1400)
        begin
            sender_gaps = 1'b0;
            recv_gaps = 1'b0;
        end
        nlines = $urandom_range(0, 9);
        for (int n = 0; n < nlines && !err_latched; n++)
        begin
            newline = (n != nlines - 1) || ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 19);
            if (!mode_contig && first_pending)
            begin
                if (pick == 0)
                    send_broken();
                else if (pick == 1)
                    send_line(1'b0, data_word(), newline);
                else
                    send_line(1'b1, start_address(), newline);
            end
            else if (pick == 0)
                send_broken();
            else if (pick <= 2)
                send_line(1'b1, next_address(), newline);
            else
                send_line(1'b0, data_word(), newline);
        end
        if (err_latched && $urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 4)) send_byte(random_byte());
        send_eoi();
    endtask

    task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= val;
        @(posedge clk);
        write_enable <= 1'b0;
        if (idx == REG_CONTIGUOUS_MODE)
            mode_contig = val[0];
        else
            base_addr = val;
        reg_writes++;
    endtask

    task automatic settle(int extra);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // output stall: short random bursts, plus one long hold when requested
    initial
    begin
        logic held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (64) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (recv_gaps && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (out_item.kind == KIND_WRITE)
                n_write++;
            else if (out_item.kind == KIND_DONE)
                n_done++;
            else
                n_error++;
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: kind %0d address %h data %h code %0d",
                       out_item.kind, out_item.address, out_item.data, out_item.error_code);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
                    mismatches++;
                end
                if (out_item.address !== want.address)
                begin
                    $error("address: expected %h, got %h", want.address, out_item.address);
                    mismatches++;
                end
                if (out_item.data !== want.data)
                begin
                    $error("data: expected %h, got %h", want.data, out_item.data);
                    mismatches++;
                end
                if (out_item.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           out_item.error_code);
                    mismatches++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_item.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #(400000 * 12);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        in_item_t    it;
        int          phase_no;
        logic [31:0] base;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        write_enable <= 1'b0;
        write_index  <= '0;
        write_data   <= '0;
        mode_contig = 1'b0;
        base_addr = '0;
        rearm_image();

        // empty image, empty first line, ignored byte after error
        add_typed(8'h00, 1'b1, make_result(KIND_DONE, '0, '0, ERR_NONE, 1'b1));
        add_typed(CHAR_NEWLINE, 1'b0, make_result(KIND_ERROR, '0, '0, ERR_NO_START, 1'b1));
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b1);
        // top address with prefix and eight digits, then a write that wraps
        add_row(CHAR_AT, 1'b0);
        add_row(CHAR_ZERO, 1'b0);
        add_row(CHAR_X_UP, 1'b0);
        repeat (8) add_row(CHAR_F_UP, 1'b0);
        add_row(CHAR_NEWLINE, 1'b0);
        add_row(CHAR_A_LOW, 1'b0);
        add_row(CHAR_COMMA, 1'b0);
        add_typed(CHAR_NEWLINE, 1'b0,
                  make_result(KIND_WRITE, 32'hFFFF_FFFF, 32'h0000_000A, ERR_NONE, 1'b0));
        // final line without newline
        add_row(CHAR_ZERO + 8'd7, 1'b0);
        add_row(8'h00, 1'b1);
        // address going backwards
        add_row(CHAR_AT, 1'b0);
        add_row(CHAR_ZERO + 8'd9, 1'b0);
        add_row(CHAR_NEWLINE, 1'b0);
        add_row(CHAR_AT, 1'b0);
        add_row(CHAR_ZERO + 8'd8, 1'b0);
        add_typed(CHAR_NEWLINE, 1'b0, make_result(KIND_ERROR, '0, '0, ERR_BACKWARDS, 1'b1));
        add_row(8'h00, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            it.char_code = directed_rows[i].ch;
            it.end_of_input = directed_rows[i].eoi;
            drive_item(it, directed_rows[i].typed, directed_rows[i].want);
        end

        phase_no = 0;
        while (items_sent < 1600)
        begin
            settle(8);
            if (phase_no == 0)
            begin
                // hold the output long enough for the input side to back up
                set_register(REG_CONTIGUOUS_MODE, 32'd1);
                set_register(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
                hold_request = 1'b1;
                sender_gaps = 1'b0;
                repeat (24) send_line(1'b0, data_word(), 1'b1);
                send_eoi();
                sender_gaps = 1'b1;
            end
            else
            begin
                case (phase_no % 4)
                    1: base = '0;
                    2: base = 32'hFFFF_FFFF;
                    3: base = 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
                    default: base = $urandom;
                endcase
                if (phase_no < 5)
                    set_register(REG_CONTIGUOUS_MODE, 32'(phase_no % 2));
                else
                    set_register(REG_CONTIGUOUS_MODE, 32'($urandom_range(0, 1)));
                set_register(REG_BASE_ADDRESS, base);
                if (items_sent < 1400)
                begin
                    sender_gaps = $urandom_range(0, 3) != 0;
                    recv_gaps = $urandom_range(0, 3) != 0;
                end
                repeat ($urandom_range(2, 5)) send_image();
            end
            phase_no++;
        end

        sender_gaps = 1'b0;
        recv_gaps = 1'b0;
        settle(20);
        $display("ran %0d items in %0d images across %0d register writes",
                 items_sent, images_sent, reg_writes);
        $display("saw %0d writes, %0d done and %0d error results, %0d mismatches",
                 n_write, n_done, n_error, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
